// ----- rtl/core/hwid_pkg.sv -----
// Package: types, register map and reset values for the hardware ID window classifier.
`timescale 1ns / 1ps
`default_nettype none

package hwid_pkg;

  localparam int unsigned ADC_BITS = 12;
  localparam int unsigned NUM_VARIANTS = 3;

  // Register map, index order of the configuration port
  typedef enum logic [2:0] {
    REG_OPEN_THR  = 3'd0,
    REG_SHORT_THR = 3'd1,
    REG_V1_NOM    = 3'd2,
    REG_V1_TOL    = 3'd3,
    REG_V2_NOM    = 3'd4,
    REG_V2_TOL    = 3'd5,
    REG_V3_NOM    = 3'd6,
    REG_V3_TOL    = 3'd7
  } cfg_reg_e;

  localparam logic [ADC_BITS-1:0] OPEN_THR_RST  = ADC_BITS'(3900);
  localparam logic [ADC_BITS-1:0] SHORT_THR_RST = ADC_BITS'(200);
  localparam logic [ADC_BITS-1:0] V1_NOM_RST    = ADC_BITS'(1024);
  localparam logic [ADC_BITS-1:0] V2_NOM_RST    = ADC_BITS'(2048);
  localparam logic [ADC_BITS-1:0] V3_NOM_RST    = ADC_BITS'(3072);
  localparam logic [ADC_BITS-1:0] TOL_RST       = ADC_BITS'(100);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OPEN     = 3'd1,
    ST_SHORT    = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_UNSTABLE = 3'd4
  } status_e;

  localparam logic [1:0] VAR_NONE = 2'd0;

  typedef struct packed {
    logic [ADC_BITS-1:0]                    open_thr;
    logic [ADC_BITS-1:0]                    short_thr;
    logic [NUM_VARIANTS-1:0][ADC_BITS-1:0]  nominal;
    logic [NUM_VARIANTS-1:0][ADC_BITS-1:0]  tolerance;
  } cfg_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] sample_code;
    logic                last_sample;
  } in_req_t;

  typedef struct packed {
    logic [2:0] run_status;
    logic [1:0] variant_id;
  } out_req_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] variant;
  } class_t;

endpackage

`default_nettype wire

// ----- rtl/core/hwid_classify.sv -----
// Single-sample classifier: open, short, first matching variant window, else unknown.
`timescale 1ns / 1ps
`default_nettype none

module hwid_window_match
  import hwid_pkg::*;
(
  input  wire logic [ADC_BITS-1:0] code_i,
  input  wire cfg_t                cfg_i,
  output class_t                   class_o
);

  logic [NUM_VARIANTS-1:0] hit;

  always_comb begin
    logic [ADC_BITS-1:0] span;
    for (int v = 0; v < NUM_VARIANTS; v++) begin
      span = (code_i >= cfg_i.nominal[v]) ? (code_i - cfg_i.nominal[v])
                                          : (cfg_i.nominal[v] - code_i);
      hit[v] = (span <= cfg_i.tolerance[v]);
    end
  end

  // open beats short when the thresholds cross; lower variant wins on overlap
  always_comb begin
    class_o.status  = ST_UNKNOWN;
    class_o.variant = VAR_NONE;
    if (code_i > cfg_i.open_thr) begin
      class_o.status = ST_OPEN;
    end else if (code_i < cfg_i.short_thr) begin
      class_o.status = ST_SHORT;
    end else if (hit[0]) begin
      class_o.status  = ST_OK;
      class_o.variant = 2'd1;
    end else if (hit[1]) begin
      class_o.status  = ST_OK;
      class_o.variant = 2'd2;
    end else if (hit[2]) begin
      class_o.status  = ST_OK;
      class_o.variant = 2'd3;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hardware_id_window_classifier.sv -----
// Top level: config registers, input stage, run tracking and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_req_i  (sample_code, last)
//  out     | output    | out_valid_o/ out_stall_i| out_req_o (run_status, variant)
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One sample per cycle sustained unless a stalled result holds back a last sample.
// A sample is classified in the input register and folded into the run state;
// the last sample of a run moves from the input register into the result
// register, and the result is valid once it is held there.
// Reset restores the register defaults and clears all run state.
// A last sample waits in the input register only while an unread result is stalled.
`timescale 1ns / 1ps
`default_nettype none

module hardware_id_window_classifier
  import hwid_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [ADC_BITS-1:0] cfg_data_i,

  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_req_t             in_req_i,

  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_req_t                 out_req_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_thr     <= OPEN_THR_RST;
      cfg_q.short_thr    <= SHORT_THR_RST;
      cfg_q.nominal[0]   <= V1_NOM_RST;
      cfg_q.nominal[1]   <= V2_NOM_RST;
      cfg_q.nominal[2]   <= V3_NOM_RST;
      cfg_q.tolerance[0] <= TOL_RST;
      cfg_q.tolerance[1] <= TOL_RST;
      cfg_q.tolerance[2] <= TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_OPEN_THR:  cfg_q.open_thr     <= cfg_data_i;
        REG_SHORT_THR: cfg_q.short_thr    <= cfg_data_i;
        REG_V1_NOM:    cfg_q.nominal[0]   <= cfg_data_i;
        REG_V1_TOL:    cfg_q.tolerance[0] <= cfg_data_i;
        REG_V2_NOM:    cfg_q.nominal[1]   <= cfg_data_i;
        REG_V2_TOL:    cfg_q.tolerance[1] <= cfg_data_i;
        REG_V3_NOM:    cfg_q.nominal[2]   <= cfg_data_i;
        REG_V3_TOL:    cfg_q.tolerance[2] <= cfg_data_i;
      endcase
    end
  end

  // Input stage
  logic    stg_valid_q;
  in_req_t stg_req_q;
  logic    stg_adv;
  logic    out_free;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign stg_adv    = stg_valid_q && (!stg_req_q.last_sample || out_free);
  assign in_stall_o = stg_valid_q && !stg_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      stg_req_q <= in_req_i;
    end
  end

  class_t cls;

  hwid_window_match u_classify (
    .code_i  (stg_req_q.sample_code),
    .cfg_i   (cfg_q),
    .class_o (cls)
  );

  // Run state
  logic       first_seen_q, first_seen_d;
  logic [1:0] first_status_q, first_status_d;
  logic [1:0] first_variant_q, first_variant_d;
  logic       run_unstable_q, run_unstable_d;
  logic       out_valid_q, out_valid_d;
  out_req_t   out_req_q, out_req_d;

  always_comb begin
    logic       seen;
    logic [1:0] f_status;
    logic [1:0] f_variant;
    logic       unstable;

    seen      = first_seen_q;
    f_status  = first_status_q;
    f_variant = first_variant_q;
    unstable  = run_unstable_q;

    if (!first_seen_q) begin
      seen      = 1'b1;
      f_status  = cls.status[1:0];
      f_variant = cls.variant;
    end else if ((cls.status != status_e'({1'b0, first_status_q}))
                 || (cls.variant != first_variant_q)) begin
      unstable = 1'b1;
    end

    first_seen_d    = first_seen_q;
    first_status_d  = first_status_q;
    first_variant_d = first_variant_q;
    run_unstable_d  = run_unstable_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_req_d       = out_req_q;

    if (stg_adv) begin
      if (stg_req_q.last_sample) begin
        first_seen_d    = 1'b0;
        first_status_d  = 2'd0;
        first_variant_d = VAR_NONE;
        run_unstable_d  = 1'b0;
        out_valid_d     = 1'b1;
        if (unstable) begin
          out_req_d.run_status = ST_UNSTABLE;
          out_req_d.variant_id = VAR_NONE;
        end else begin
          out_req_d.run_status = {1'b0, f_status};
          out_req_d.variant_id = f_variant;
        end
      end else begin
        first_seen_d    = seen;
        first_status_d  = f_status;
        first_variant_d = f_variant;
        run_unstable_d  = unstable;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seen_q    <= 1'b0;
      first_status_q  <= 2'd0;
      first_variant_q <= VAR_NONE;
      run_unstable_q  <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      first_seen_q    <= first_seen_d;
      first_status_q  <= first_status_d;
      first_variant_q <= first_variant_d;
      run_unstable_q  <= run_unstable_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

`default_nettype wire
